>>> hdl/speck64_128_block_cipher_core_assert.svh
// Concurrent checks sampled on clk, inactive while arst_n is low.
`ifndef SPECK64_128_BLOCK_CIPHER_CORE_ASSERT_SVH
`define SPECK64_128_BLOCK_CIPHER_CORE_ASSERT_SVH

// Condition holds in the same cycle.
`define SPK_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Condition holds in the next cycle.
`define SPK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

>>> hdl/spk_pkg.sv
package spk_pkg;

	localparam int WORD_W        = 32;
	localparam int ROUNDS_DEF    = 27;
	localparam int KEY_WORDS_DEF = 4;
	localparam int KEY_REGS      = 4;
	localparam int KEY_IDX_W     = 2;
	localparam int CFG_IDX_W     = 8;
	localparam int ROT_A         = 8;
	localparam int ROT_B         = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [1:0]        shift_t;

	localparam shift_t SH_HOLD = 2'd0;
	localparam shift_t SH_FWD  = 2'd1;
	localparam shift_t SH_BWD  = 2'd2;

endpackage

>>> hdl/spk_key_cell.sv
module spk_key_cell (
	input  logic           clk,
	input  spk_pkg::shift_t shift,
	input  spk_pkg::word_t d_fwd,
	input  spk_pkg::word_t d_bwd,
	output spk_pkg::word_t q
);
	import spk_pkg::*;

	word_t key_q;

	always_ff @(posedge clk) begin
		case (shift)
			SH_FWD:  key_q <= d_fwd;
			SH_BWD:  key_q <= d_bwd;
			default: key_q <= key_q;
		endcase
	end

	assign q = key_q;

endmodule

>>> hdl/spk_round.sv
module spk_round (
	input  logic           dec,
	input  spk_pkg::word_t x,
	input  spk_pkg::word_t y,
	input  spk_pkg::word_t k,
	output spk_pkg::word_t x_n,
	output spk_pkg::word_t y_n
);
	import spk_pkg::*;

	word_t ex, ey, dx, dy, dt;

	always_comb begin
		ex = ({x[ROT_A-1:0], x[WORD_W-1:ROT_A]} + y) ^ k;
		ey = {y[WORD_W-ROT_B-1:0], y[WORD_W-1:WORD_W-ROT_B]} ^ ex;
		dt = y ^ x;
		dy = {dt[ROT_B-1:0], dt[WORD_W-1:ROT_B]};
		dt = (x ^ k) - dy;
		dx = {dt[WORD_W-ROT_A-1:0], dt[WORD_W-1:WORD_W-ROT_A]};
		x_n = dec ? dx : ex;
		y_n = dec ? dy : ey;
	end

endmodule

>>> hdl/speck64_128_block_cipher_core.sv
// Speck64/128 core, one round per cycle on a shared round unit; the last round stalls while
// an earlier result still waits on m_tready. The first word after reset or a key write is
// preceded by key expansion on the same round unit.
// A new word is accepted only when idle, after the last one has left the iterative round loop.
// Round keys circulate in a ring of 27 key cells, forward to encrypt, back to decrypt.
// Reset clears control state and key registers; round keys are rebuilt before use.
module speck64_128_block_cipher_core #(
	parameter int ROUNDS    = spk_pkg::ROUNDS_DEF,
	parameter int KEY_WORDS = spk_pkg::KEY_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [spk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  spk_pkg::word_t                 cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [2*spk_pkg::WORD_W-1:0]   s_tdata,  // word_x, word_y
	input  logic                           s_tuser,  // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [2*spk_pkg::WORD_W-1:0]   m_tdata   // out_x, out_y
);
	import spk_pkg::*;

	localparam int CNT_W = $clog2(ROUNDS);
	localparam int LQ_N  = KEY_WORDS - 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXPAND = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              keys_ready_q;
	logic              cmd_q;
	logic              out_valid_q;
	word_t             x_q, y_q, k_q, out_x_q, out_y_q;
	word_t             key_q [KEY_REGS];
	word_t             lq_q [LQ_N];
	word_t             rk [ROUNDS];

	logic              cnt_last, advance, in_acc, cfg_acc, r_dec;
	word_t             r_x, r_y, r_k, r_xn, r_yn, tail_d, k_new;
	shift_t            shift;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cnt_last  = (cnt_q == CNT_W'(ROUNDS - 1));
	assign advance   = !(cnt_last && out_valid_q && !m_tready);

	always_comb begin
		if (state_q == ST_EXPAND) begin
			r_dec = 1'b0;
			r_x   = lq_q[0];
			r_y   = k_q;
			r_k   = {{(WORD_W-CNT_W){1'b0}}, cnt_q - CNT_W'(1)};
		end else begin
			r_dec = cmd_q;
			r_x   = x_q;
			r_y   = y_q;
			r_k   = cmd_q ? rk[ROUNDS-1] : rk[0];
		end
	end

	spk_round u_round (
		.dec (r_dec),
		.x   (r_x),
		.y   (r_y),
		.k   (r_k),
		.x_n (r_xn),
		.y_n (r_yn)
	);

	assign k_new  = (cnt_q == '0) ? key_q[KEY_WORDS-1] : r_yn;
	assign tail_d = (state_q == ST_EXPAND) ? k_new : rk[0];

	always_comb begin
		unique case (state_q)
			ST_EXPAND: shift = SH_FWD;
			ST_RUN:    shift = advance ? (cmd_q ? SH_BWD : SH_FWD) : SH_HOLD;
			default:   shift = SH_HOLD;
		endcase
	end

	for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
		word_t d_fwd, d_bwd;
		if (g == ROUNDS - 1) begin : g_tail
			assign d_fwd = tail_d;
		end else begin : g_mid_f
			assign d_fwd = rk[g+1];
		end
		if (g == 0) begin : g_head
			assign d_bwd = rk[ROUNDS-1];
		end else begin : g_mid_b
			assign d_bwd = rk[g-1];
		end
		spk_key_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d_fwd (d_fwd),
			.d_bwd (d_bwd),
			.q     (rk[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			keys_ready_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < KEY_REGS; i++) begin
				key_q[i] <= '0;
			end
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						state_q <= keys_ready_q ? ST_RUN : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (cnt_last) begin
						cnt_q        <= '0;
						state_q      <= ST_RUN;
						keys_ready_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_RUN: begin
					if (advance) begin
						if (cnt_last) begin
							cnt_q       <= '0;
							state_q     <= ST_IDLE;
							out_valid_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_acc && (cfg_index < CFG_IDX_W'(KEY_REGS))) begin
				key_q[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
				keys_ready_q                    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= s_tuser;
			x_q   <= s_tdata[WORD_W-1:0];
			y_q   <= s_tdata[2*WORD_W-1:WORD_W];
		end else if (state_q == ST_RUN && advance) begin
			x_q <= r_xn;
			y_q <= r_yn;
		end
		if (state_q == ST_EXPAND) begin
			k_q <= k_new;
			if (cnt_q == '0) begin
				for (int t = 0; t < LQ_N; t++) begin
					lq_q[t] <= key_q[KEY_WORDS-2-t];
				end
			end else begin
				for (int t = 0; t < LQ_N - 1; t++) begin
					lq_q[t] <= lq_q[t+1];
				end
				lq_q[LQ_N-1] <= r_xn;
			end
		end
		if (state_q == ST_RUN && advance && cnt_last) begin
			out_x_q <= r_xn;
			out_y_q <= r_yn;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};

`include "speck64_128_block_cipher_core_assert.svh"

	`SPK_ASSERT_NEXT(a_key_write_stale, cfg_acc && (cfg_index < CFG_IDX_W'(KEY_REGS)), !keys_ready_q)
	`SPK_ASSERT_NEXT(a_expand_to_run, state_q == ST_EXPAND && cnt_last, state_q == ST_RUN)
	`SPK_ASSERT_NEXT(a_accept_busy, in_acc, state_q == ST_EXPAND || state_q == ST_RUN)
	`SPK_ASSERT_NEXT(a_result_out, state_q == ST_RUN && cnt_last && !out_valid_q, out_valid_q)

endmodule
